// File: hw/rtl/bitmap_page_run_allocator_core_assert.svh
// Assertion macros shared by the page run allocator RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPRUN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BPRUN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BPRUN_ASSERT(lbl, clk, rst_n, prop, msg)
`define BPRUN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/bprun_pkg.sv
// Package of the page run allocator: sizes, codes and transaction types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bprun_pkg;

    localparam int MAX_PAGES  = 4096;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(MAP_WORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int PAGE_W     = 12;
    localparam int COUNT_W    = 13;
    localparam int NEED_W     = 27;
    localparam int K_W        = 5;
    localparam int FREED_W    = BIT_IDX_W + 1;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [COUNT_W-1:0] MAX_PAGES_C   = COUNT_W'(MAX_PAGES);
    localparam logic [K_W-1:0]     K_MIN         = 5'd6;
    localparam logic [K_W-1:0]     K_MAX         = 5'd20;
    localparam logic [K_W-1:0]     K_RESET       = 5'd12;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_RUN    = 2'd1,
        ST_BAD_REQ   = 2'd2,
        ST_BAD_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_POOL_ENABLED   = 2'd0,
        REG_PAGES_IN_USE   = 2'd1,
        REG_PAGE_SIZE_LOG2 = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_op                 operation;
        logic [31:0]         size_bytes;
        logic [PAGE_W-1:0]   release_first_page;
        logic [COUNT_W-1:0]  release_pages;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [PAGE_W-1:0]   first_page;
        logic [COUNT_W-1:0]  granted_pages;
        logic [COUNT_W-1:0]  used_pages;
    } t_out_item;

    typedef struct packed {
        logic [WORD_IDX_W-1:0] word_idx;
        logic [COUNT_W-1:0]    lim;
        logic [COUNT_W-1:0]    run_in;
        logic [COUNT_W-1:0]    need;
        logic [PAGE_W-1:0]     first;
        logic [PAGE_W-1:0]     last;
        logic                  release_op;
    } t_unit_req;

    typedef struct packed {
        logic                  hit;
        logic [BIT_IDX_W-1:0]  hit_pos;
        logic [COUNT_W-1:0]    run_out;
        logic [FREED_W-1:0]    freed;
        t_word                 new_word;
    } t_unit_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/bprun_map.sv
// Free-page bitmap storage: one word per row, one read and one write port.
// Rows never written read as all free. Depends on bprun_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bprun_map (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire [bprun_pkg::WORD_IDX_W-1:0]  i_rd_addr,
    output bprun_pkg::t_word                 o_rd_data,
    input  wire                              i_wr_en,
    input  wire [bprun_pkg::WORD_IDX_W-1:0]  i_wr_addr,
    input  wire bprun_pkg::t_word            i_wr_data
);
    import bprun_pkg::*;

    t_word                r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_valid;
    t_word                r_rd_data;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : {WORD_BITS{1'b1}};

endmodule

`default_nettype wire

// File: hw/rtl/bprun_word_unit.sv
// Shared bitmap word unit: run search over one word, and the set or clear
// of a page range within one word with a count of freed pages. Uses bprun_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bprun_word_unit (
    input  wire bprun_pkg::t_word     i_word,
    input  wire bprun_pkg::t_unit_req i_req,
    output bprun_pkg::t_unit_rsp      o_rsp
);
    import bprun_pkg::*;

    function automatic logic [BIT_IDX_W-1:0] msb_idx(input t_word v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [BIT_IDX_W-1:0] lsb_idx(input t_word v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [FREED_W-1:0] ones_count(input t_word v);
        logic [FREED_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            sum = sum + FREED_W'(v[i]);
        end
        return sum;
    endfunction

    logic [COUNT_W:0]     lim_diff;
    t_word                lim_mask;
    t_word                free_bits;
    logic [COUNT_W:0]     run_at [WORD_BITS];
    t_word                hits;
    logic [BIT_IDX_W-1:0] lo_bit;
    logic [BIT_IDX_W-1:0] hi_bit;
    t_word                range_mask;

    assign lim_diff = {1'b0, i_req.lim} - (COUNT_W + 1)'({i_req.word_idx, {BIT_IDX_W{1'b0}}});

    always_comb begin
        priority if (lim_diff[COUNT_W] || (lim_diff == '0)) begin
            lim_mask = '0;
        end else if (lim_diff >= (COUNT_W + 1)'(WORD_BITS)) begin
            lim_mask = {WORD_BITS{1'b1}};
        end else begin
            lim_mask = ~({WORD_BITS{1'b1}} << lim_diff[BIT_IDX_W-1:0]);
        end
    end

    assign free_bits = i_word & lim_mask;

    for (genvar j = 0; j < WORD_BITS; j++) begin : g_pos
        t_word used_low;
        assign used_low  = ~free_bits & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - j));
        assign run_at[j] = (used_low == '0)
                         ? ((COUNT_W + 1)'(i_req.run_in) + (COUNT_W + 1)'(j + 1))
                         : ((COUNT_W + 1)'(j) - (COUNT_W + 1)'(msb_idx(used_low)));
        assign hits[j]   = (run_at[j] == {1'b0, i_req.need});
    end

    assign lo_bit = (i_req.word_idx == i_req.first[PAGE_W-1:BIT_IDX_W])
                  ? i_req.first[BIT_IDX_W-1:0] : '0;
    assign hi_bit = (i_req.word_idx == i_req.last[PAGE_W-1:BIT_IDX_W])
                  ? i_req.last[BIT_IDX_W-1:0] : {BIT_IDX_W{1'b1}};
    assign range_mask = ({WORD_BITS{1'b1}} << lo_bit)
                      & ({WORD_BITS{1'b1}} >> ({BIT_IDX_W{1'b1}} - hi_bit));

    assign o_rsp.hit      = |hits;
    assign o_rsp.hit_pos  = lsb_idx(hits);
    assign o_rsp.run_out  = run_at[WORD_BITS-1][COUNT_W-1:0];
    assign o_rsp.freed    = ones_count(~i_word & range_mask);
    assign o_rsp.new_word = i_req.release_op ? (i_word | range_mask) : (i_word & ~range_mask);

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_page_run_allocator_core.sv
// An accepted acquire steps through the states CALC, CHECK, SCAN (one bitmap word
// per step, at most ceil(pages_in_use/64) words, so 64 for 4096 pages), then
// MARK_RD and MARK_WR for each word the granted run touches, and FIN; a release
// steps through CALC, CHECK, MARK_RD and MARK_WR for each word of its run, and
// FIN; a request refused at once goes from CHECK to FIN. The next transaction is
// accepted in IDLE. The two-port bitmap memory and the one shared word unit,
// which handle one 64-page word at a time, set this order. One transaction is in
// work at a time; a finished result waits in an output register while the next
// is accepted, and a result that finds that register still full waits until taken.
// Top level of the page run allocator: sequencer, registers and APB port.
// Depends on bprun_pkg, bprun_map, bprun_word_unit and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_run_allocator_core_assert.svh"

module bitmap_page_run_allocator_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire bprun_pkg::t_in_item       i_in_data,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output bprun_pkg::t_out_item           o_out_data,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [bprun_pkg::PADDR_W-1:0]   paddr,
    input  wire [bprun_pkg::PDATA_W-1:0]   pwdata,
    output logic [bprun_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);
    import bprun_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CALC    = 7'b0000010,
        S_CHECK   = 7'b0000100,
        S_SCAN    = 7'b0001000,
        S_MARK_RD = 7'b0010000,
        S_MARK_WR = 7'b0100000,
        S_FIN     = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [31:0]           r_size, n_size;
    logic [K_W-1:0]        r_k, n_k;
    logic [PAGE_W-1:0]     r_rfirst, n_rfirst;
    logic [COUNT_W-1:0]    r_rcount, n_rcount;
    logic [NEED_W-1:0]     r_need, n_need;
    logic [WORD_IDX_W-1:0] r_word, n_word;
    logic [COUNT_W-1:0]    r_run, n_run;
    logic [PAGE_W-1:0]     r_first, n_first;
    logic [PAGE_W-1:0]     r_last, n_last;
    logic [COUNT_W-1:0]    r_used, n_used;
    logic [FREED_W-1:0]    r_freed, n_freed;
    t_status               r_status, n_status;
    logic [PAGE_W-1:0]     r_gfirst, n_gfirst;
    logic [COUNT_W-1:0]    r_gcount, n_gcount;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;
    logic                  r_pool_enabled;
    logic [COUNT_W-1:0]    r_pages_in_use;
    logic [K_W-1:0]        r_page_size_log2;

    logic                  cfg_write;
    logic [COUNT_W-1:0]    lim;
    logic [K_W-1:0]        k_clamped;
    logic [32:0]           round_sum;
    logic [COUNT_W:0]      rel_end;
    logic [COUNT_W-1:0]    hit_start;
    logic                  fin_fire;
    logic [WORD_IDX_W-1:0] rd_addr;
    t_word                 rd_word;
    t_unit_req             unit_req;
    t_unit_rsp             unit_rsp;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_enabled   <= 1'b1;
            r_pages_in_use   <= MAX_PAGES_C;
            r_page_size_log2 <= K_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_POOL_ENABLED:   r_pool_enabled   <= pwdata[0];
                REG_PAGES_IN_USE:   r_pages_in_use   <= pwdata[COUNT_W-1:0];
                REG_PAGE_SIZE_LOG2: r_page_size_log2 <= pwdata[K_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_POOL_ENABLED:   prdata = PDATA_W'(r_pool_enabled);
            REG_PAGES_IN_USE:   prdata = PDATA_W'(r_pages_in_use);
            REG_PAGE_SIZE_LOG2: prdata = PDATA_W'(r_page_size_log2);
            default:            prdata = '0;
        endcase
    end

    assign lim = (r_pages_in_use > MAX_PAGES_C) ? MAX_PAGES_C : r_pages_in_use;

    always_comb begin
        priority if (r_page_size_log2 < K_MIN) begin
            k_clamped = K_MIN;
        end else if (r_page_size_log2 > K_MAX) begin
            k_clamped = K_MAX;
        end else begin
            k_clamped = r_page_size_log2;
        end
    end

    assign round_sum = {1'b0, r_size} + ((33'd1 << r_k) - 33'd1);
    assign rel_end   = (COUNT_W + 1)'(r_rfirst) + (COUNT_W + 1)'(r_rcount);
    assign hit_start = COUNT_W'({r_word, unit_rsp.hit_pos}) + COUNT_W'(1) - r_need[COUNT_W-1:0];

    // Bitmap memory and the shared word unit.
    always_comb begin
        priority if (r_state == S_SCAN) begin
            rd_addr = r_word + WORD_IDX_W'(1);
        end else if (r_state == S_MARK_RD) begin
            rd_addr = r_word;
        end else begin
            rd_addr = '0;
        end
    end

    bprun_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word),
        .i_wr_en   (r_state == S_MARK_WR),
        .i_wr_addr (r_word),
        .i_wr_data (unit_rsp.new_word)
    );

    assign unit_req.word_idx   = r_word;
    assign unit_req.lim        = lim;
    assign unit_req.run_in     = r_run;
    assign unit_req.need       = r_need[COUNT_W-1:0];
    assign unit_req.first      = r_first;
    assign unit_req.last       = r_last;
    assign unit_req.release_op = (r_op == OP_RELEASE);

    bprun_word_unit u_word_unit (
        .i_word (rd_word),
        .i_req  (unit_req),
        .o_rsp  (unit_rsp)
    );

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_size      = r_size;
        n_k         = r_k;
        n_rfirst    = r_rfirst;
        n_rcount    = r_rcount;
        n_need      = r_need;
        n_word      = r_word;
        n_run       = r_run;
        n_first     = r_first;
        n_last      = r_last;
        n_freed     = '0;
        n_status    = r_status;
        n_gfirst    = r_gfirst;
        n_gcount    = r_gcount;
        fin_fire    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.operation;
                    n_size   = i_in_data.size_bytes;
                    n_rfirst = i_in_data.release_first_page;
                    n_rcount = i_in_data.release_pages;
                    n_k      = k_clamped;
                    n_state  = S_CALC;
                end
            end
            S_CALC: begin
                n_need  = NEED_W'(round_sum >> r_k);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_status = ST_OK;
                n_gfirst = '0;
                n_gcount = '0;
                n_run    = '0;
                n_word   = '0;
                n_state  = S_FIN;
                priority if (!r_pool_enabled) begin
                    n_status = ST_BAD_REQ;
                end else if (r_op == OP_ACQUIRE) begin
                    priority if (r_size == '0) begin
                        n_status = ST_BAD_REQ;
                    end else if (r_need > NEED_W'(lim)) begin
                        n_status = ST_NO_RUN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (r_rcount != '0) begin
                    if (rel_end > (COUNT_W + 1)'(lim)) begin
                        n_status = ST_BAD_RANGE;
                    end else begin
                        n_first = r_rfirst;
                        n_last  = PAGE_W'(rel_end - (COUNT_W + 1)'(1));
                        n_word  = r_rfirst[PAGE_W-1:BIT_IDX_W];
                        n_state = S_MARK_RD;
                    end
                end
            end
            S_SCAN: begin
                priority if (unit_rsp.hit) begin
                    n_first  = hit_start[PAGE_W-1:0];
                    n_last   = {r_word, unit_rsp.hit_pos};
                    n_word   = hit_start[PAGE_W-1:BIT_IDX_W];
                    n_gfirst = hit_start[PAGE_W-1:0];
                    n_gcount = r_need[COUNT_W-1:0];
                    n_state  = S_MARK_RD;
                end else if (COUNT_W'({r_word + WORD_IDX_W'(1), {BIT_IDX_W{1'b0}}}) >= lim
                             || r_word == {WORD_IDX_W{1'b1}}) begin
                    n_status = ST_NO_RUN;
                    n_state  = S_FIN;
                end else begin
                    n_word = r_word + WORD_IDX_W'(1);
                    n_run  = unit_rsp.run_out;
                end
            end
            S_MARK_RD: begin
                n_state = S_MARK_WR;
            end
            S_MARK_WR: begin
                if (r_op == OP_RELEASE) begin
                    n_freed = unit_rsp.freed;
                end
                if (r_word == r_last[PAGE_W-1:BIT_IDX_W]) begin
                    n_state = S_FIN;
                end else begin
                    n_word  = r_word + WORD_IDX_W'(1);
                    n_state = S_MARK_RD;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    fin_fire = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_used      = r_used - COUNT_W'(r_freed) + (fin_fire ? r_gcount : '0);
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (fin_fire) begin
            n_out_valid         = 1'b1;
            n_out.status        = r_status;
            n_out.first_page    = r_gfirst;
            n_out.granted_pages = r_gcount;
            n_out.used_pages    = n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_freed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_freed     <= n_freed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_size   <= n_size;
        r_k      <= n_k;
        r_rfirst <= n_rfirst;
        r_rcount <= n_rcount;
        r_need   <= n_need;
        r_word   <= n_word;
        r_run    <= n_run;
        r_first  <= n_first;
        r_last   <= n_last;
        r_status <= n_status;
        r_gfirst <= n_gfirst;
        r_gcount <= n_gcount;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BPRUN_ASSERT(a_used_bounded, i_clk, i_rst_n, r_used <= MAX_PAGES_C,
        "used page count exceeds the page capacity")
    `BPRUN_ASSERT_IMP(a_scan_below_limit, i_clk, i_rst_n, r_state == S_SCAN,
        COUNT_W'({r_word, {BIT_IDX_W{1'b0}}}) < lim,
        "scan reached a word beyond the page limit")
    `BPRUN_ASSERT_IMP(a_mark_in_run, i_clk, i_rst_n, r_state == S_MARK_WR,
        r_word >= r_first[PAGE_W-1:BIT_IDX_W] && r_word <= r_last[PAGE_W-1:BIT_IDX_W],
        "marked word lies outside the run")
    `BPRUN_ASSERT_IMP(a_grant_in_limit, i_clk, i_rst_n,
        r_out_valid && r_out.granted_pages != '0,
        (COUNT_W + 1)'(r_out.first_page) + (COUNT_W + 1)'(r_out.granted_pages)
            <= (COUNT_W + 1)'(lim),
        "granted run extends beyond the page limit")

endmodule

`default_nettype wire
